>>> rtl/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and codes of the cursor array list core.
// ----------------------------------------------------------------------------
package cal_pkg;

	localparam int ACT_W    = 4;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 10;
	localparam int STATUS_W = 3;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 11;
	localparam int CURSOR_W = 10;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_BEFORE = 4'd0,
		ACT_INS_AFTER  = 4'd1,
		ACT_DELETE     = 4'd2,
		ACT_PREV       = 4'd3,
		ACT_NEXT       = 4'd4,
		ACT_FIRST      = 4'd5,
		ACT_LAST       = 4'd6,
		ACT_READ_CUR   = 4'd7,
		ACT_READ_IDX   = 4'd8,
		ACT_WRITE_IDX  = 4'd9
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_BOUND  = 3'd2,
		ST_BADIDX = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef struct packed {
		logic go;
		logic up;
	} seq_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_sts_t;

endpackage

>>> rtl/cal_ram.sv
// ----------------------------------------------------------------------------
// cal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/cal_seq.sv
// ----------------------------------------------------------------------------
// cal_seq
// Shift sequencer: walks an index from start to stop, reading one entry per
// cycle and writing it back one place up or down on the following cycle.
// ----------------------------------------------------------------------------
module cal_seq #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cal_pkg::seq_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0] start_idx,
	input  logic [$clog2(DEPTH)-1:0] stop_idx,
	output cal_pkg::seq_sts_t        sts,
	output logic                     rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr
);

	localparam int AW = $clog2(DEPTH);

	logic          run_q;
	logic          up_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] stop_q;
	logic          wr_s1;
	logic [AW-1:0] wa_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= run_q;
			if (ctl.go) begin
				run_q <= 1'b1;
			end else if (run_q && idx_q == stop_q) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			up_q   <= ctl.up;
			idx_q  <= start_idx;
			stop_q <= stop_idx;
		end else if (run_q && idx_q != stop_q) begin
			idx_q <= up_q ? idx_q - AW'(1) : idx_q + AW'(1);
		end
		wa_s1 <= up_q ? idx_q + AW'(1) : idx_q - AW'(1);
	end

	assign rd_en    = run_q;
	assign rd_addr  = idx_q;
	assign wr_en    = wr_s1;
	assign wr_addr  = wa_s1;
	assign sts.busy = run_q | wr_s1;
	assign sts.done = wr_s1 & ~run_q;

endmodule

>>> rtl/cursor_array_list_core.sv
// ----------------------------------------------------------------------------
// cursor_array_list_core
// Ordered list in a RAM with a length and a cursor on the current entry.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one request per transfer, action in s_tuser, value and
//   position in s_tdata. Master channel: one result per request, status in
//   m_tuser, read data, entry count and cursor index in m_tdata.
//   Requests are handled one at a time; s_tready is low from the accepted
//   transfer until the result is loaded into the output register.
//   Each request passes through a decode state and then the response state,
//   which loads the output register; reads add a read state, accepted inserts
//   a write state for the new entry, and inserts and deletes that move entries
//   first a shift state. Indexed writes write the RAM from the decode state.
//   Inserts and deletes move every entry behind the insertion or deletion
//   point through the shift sequencer, one entry per cycle over the single
//   RAM port pair.
//   Reset empties the list and puts the cursor at index 0; RAM contents are
//   not cleared and are only read after being written.
//   A stalled master side holds the result in the output register; the next
//   request is accepted and runs, then waits until that result is taken.
// ----------------------------------------------------------------------------
module cursor_array_list_core #(
	parameter int DEPTH      = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // value[31:0], position[41:32], zero fill
	input  logic [3:0]  s_tuser,   // action[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // data[31:0], count[42:32], cursor_at[52:43], zero fill
	output logic [2:0]  m_tuser    // status[2:0]
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam int CW = (LW > cal_pkg::POS_W) ? LW : cal_pkg::POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT,
		S_WRITE,
		S_READ,
		S_RESP
	} state_t;

	state_t                          state_q;
	state_t                          nxt_state;
	logic [LW-1:0]                   len_q;
	logic [AW-1:0]                   cur_q;
	logic                            wr_then_q;
	logic                            m_tvalid_q;

	cal_pkg::action_t                act_q;
	logic [DATA_WIDTH-1:0]           val_q;
	logic [cal_pkg::POS_W-1:0]       pos_q;
	logic [AW-1:0]                   wa_q;
	cal_pkg::status_t                status_q;
	logic [DATA_WIDTH-1:0]           data_q;

	logic [cal_pkg::STATUS_W-1:0]    m_status_q;
	logic [cal_pkg::DATA_W-1:0]      m_data_q;
	logic [cal_pkg::COUNT_W-1:0]     m_count_q;
	logic [cal_pkg::CURSOR_W-1:0]    m_cursor_q;

	logic [LW-1:0]                   nxt_len;
	logic [AW-1:0]                   nxt_cur;
	cal_pkg::status_t                nxt_status;
	logic                            nxt_wr_then;
	logic [AW-1:0]                   nxt_wa;
	logic                            dec_rd;
	logic [AW-1:0]                   dec_raddr;
	logic                            dec_wr;
	logic [AW-1:0]                   last_idx;
	logic [LW-1:0]                   cur_p1_ext;
	logic [AW-1:0]                   cur_p1;
	logic                            at_last;
	logic                            pos_ok;
	logic                            resp_fire;

	cal_pkg::seq_ctl_t               seq_ctl;
	cal_pkg::seq_sts_t               seq_sts;
	logic [AW-1:0]                   seq_start;
	logic [AW-1:0]                   seq_stop;
	logic                            seq_rd_en;
	logic [AW-1:0]                   seq_rd_addr;
	logic                            seq_wr_en;
	logic [AW-1:0]                   seq_wr_addr;

	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [DATA_WIDTH-1:0]           ram_wdata;
	logic                            ram_re;
	logic [AW-1:0]                   ram_raddr;
	logic [DATA_WIDTH-1:0]           ram_rdata;

	assign last_idx   = AW'(len_q - LW'(1));
	assign cur_p1_ext = LW'(cur_q) + LW'(1);
	assign cur_p1     = AW'(cur_p1_ext);
	assign at_last    = (cur_p1_ext == len_q);
	assign pos_ok     = CW'(pos_q) < CW'(len_q);
	assign resp_fire  = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	always_comb begin
		nxt_state   = S_RESP;
		nxt_len     = len_q;
		nxt_cur     = cur_q;
		nxt_status  = cal_pkg::ST_OK;
		nxt_wr_then = 1'b0;
		nxt_wa      = cur_q;
		dec_rd      = 1'b0;
		dec_raddr   = cur_q;
		dec_wr      = 1'b0;
		seq_ctl.go  = 1'b0;
		seq_ctl.up  = 1'b1;
		seq_start   = last_idx;
		seq_stop    = cur_q;
		unique case (act_q) inside
			cal_pkg::ACT_INS_BEFORE, cal_pkg::ACT_INS_AFTER: begin
				if (len_q == LW'(DEPTH)) begin
					nxt_status = cal_pkg::ST_FULL;
				end else if (len_q == '0) begin
					nxt_wa    = '0;
					nxt_cur   = '0;
					nxt_len   = LW'(1);
					nxt_state = S_WRITE;
				end else if (act_q == cal_pkg::ACT_INS_BEFORE) begin
					seq_ctl.go  = 1'b1;
					nxt_wa      = cur_q;
					nxt_cur     = cur_p1;
					nxt_len     = len_q + LW'(1);
					nxt_wr_then = 1'b1;
					nxt_state   = S_SHIFT;
				end else begin
					nxt_wa   = cur_p1;
					nxt_len  = len_q + LW'(1);
					seq_stop = cur_p1;
					if (at_last) begin
						nxt_state = S_WRITE;
					end else begin
						seq_ctl.go  = 1'b1;
						nxt_wr_then = 1'b1;
						nxt_state   = S_SHIFT;
					end
				end
			end
			cal_pkg::ACT_DELETE: begin
				seq_ctl.up = 1'b0;
				seq_start  = cur_p1;
				seq_stop   = last_idx;
				if (len_q == '0) begin
					nxt_status = cal_pkg::ST_EMPTY;
				end else if (at_last && cur_q != '0) begin
					nxt_cur = cur_q - AW'(1);
					nxt_len = len_q - LW'(1);
				end else begin
					nxt_len = len_q - LW'(1);
					if (!at_last) begin
						seq_ctl.go = 1'b1;
						nxt_state  = S_SHIFT;
					end
				end
			end
			cal_pkg::ACT_PREV: begin
				if (len_q == '0) begin
					nxt_status = cal_pkg::ST_EMPTY;
				end else if (cur_q == '0) begin
					nxt_status = cal_pkg::ST_BOUND;
				end else begin
					nxt_cur = cur_q - AW'(1);
				end
			end
			cal_pkg::ACT_NEXT: begin
				if (len_q == '0) begin
					nxt_status = cal_pkg::ST_EMPTY;
				end else if (cur_p1_ext >= len_q) begin
					nxt_status = cal_pkg::ST_BOUND;
				end else begin
					nxt_cur = cur_p1;
				end
			end
			cal_pkg::ACT_FIRST: begin
				if (len_q == '0) begin
					nxt_status = cal_pkg::ST_EMPTY;
				end else begin
					nxt_cur = '0;
				end
			end
			cal_pkg::ACT_LAST: begin
				if (len_q == '0) begin
					nxt_status = cal_pkg::ST_EMPTY;
				end else begin
					nxt_cur = last_idx;
				end
			end
			cal_pkg::ACT_READ_CUR: begin
				if (len_q == '0) begin
					nxt_status = cal_pkg::ST_EMPTY;
				end else if (LW'(cur_q) >= len_q) begin
					nxt_status = cal_pkg::ST_BADIDX;
				end else begin
					dec_rd    = 1'b1;
					nxt_state = S_READ;
				end
			end
			cal_pkg::ACT_READ_IDX: begin
				dec_raddr = AW'(pos_q);
				if (!pos_ok) begin
					nxt_status = cal_pkg::ST_BADIDX;
				end else begin
					dec_rd    = 1'b1;
					nxt_state = S_READ;
				end
			end
			cal_pkg::ACT_WRITE_IDX: begin
				nxt_wa = AW'(pos_q);
				if (!pos_ok) begin
					nxt_status = cal_pkg::ST_BADIDX;
				end else begin
					dec_wr = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q != S_DECODE) begin
			seq_ctl.go = 1'b0;
			dec_rd     = 1'b0;
			dec_wr     = 1'b0;
		end
	end

	always_comb begin
		if (seq_sts.busy) begin
			ram_we    = seq_wr_en;
			ram_waddr = seq_wr_addr;
			ram_wdata = ram_rdata;
			ram_re    = seq_rd_en;
			ram_raddr = seq_rd_addr;
		end else begin
			ram_we    = dec_wr || (state_q == S_WRITE);
			ram_waddr = dec_wr ? nxt_wa : wa_q;
			ram_wdata = val_q;
			ram_re    = dec_rd;
			ram_raddr = dec_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			cur_q      <= '0;
			wr_then_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (resp_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q   <= nxt_state;
					len_q     <= nxt_len;
					cur_q     <= nxt_cur;
					wr_then_q <= nxt_wr_then;
				end
				S_SHIFT: begin
					if (seq_sts.done) begin
						state_q <= wr_then_q ? S_WRITE : S_RESP;
					end
				end
				S_WRITE: begin
					state_q <= S_RESP;
				end
				S_READ: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			act_q <= cal_pkg::action_t'(s_tuser);
			val_q <= DATA_WIDTH'(s_tdata[31:0]);
			pos_q <= s_tdata[41:32];
		end
		if (state_q == S_DECODE) begin
			status_q <= nxt_status;
			wa_q     <= nxt_wa;
			data_q   <= '0;
		end
		if (state_q == S_READ) begin
			data_q <= ram_rdata;
		end
		if (resp_fire) begin
			m_status_q <= status_q;
			m_data_q   <= cal_pkg::DATA_W'(data_q);
			m_count_q  <= cal_pkg::COUNT_W'(len_q);
			m_cursor_q <= cal_pkg::CURSOR_W'(cur_q);
		end
	end

	cal_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (seq_ctl),
		.start_idx(seq_start),
		.stop_idx (seq_stop),
		.sts      (seq_sts),
		.rd_en    (seq_rd_en),
		.rd_addr  (seq_rd_addr),
		.wr_en    (seq_wr_en),
		.wr_addr  (seq_wr_addr)
	);

	cal_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {3'b000, m_cursor_q, m_count_q, m_data_q};

endmodule

>>> rtl/cal_chk.sv
// ----------------------------------------------------------------------------
// cal_chk
// Port-level checks of the cursor array list core, bound to the top level.
// ----------------------------------------------------------------------------
module cal_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [2:0]  m_tuser
);

	logic [10:0] count;
	logic [9:0]  cursor_at;
	logic [31:0] data;

	assign data      = m_tdata[31:0];
	assign count     = m_tdata[42:32];
	assign cursor_at = m_tdata[52:43];

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == cal_pkg::ST_EMPTY |-> count == '0 && cursor_at == '0)
		else $error("empty status with entries or moved cursor");

	a_cursor_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && count != '0 |-> {1'b0, cursor_at} < count)
		else $error("cursor beyond list");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cal_pkg::ST_OK |-> data == '0)
		else $error("data on failed request");

endmodule

bind cursor_array_list_core cal_chk u_cal_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> bench/tb_cursor_array_list_core.sv
// ----------------------------------------------------------------------------
// tb_cursor_array_list_core
// Self-checking bench for the cursor array list core. A queue of requests
// (directed corner cases, random mixes sized to keep the list short, and a
// closing run of boundary cases) feeds a bursty stream driver. Each accepted
// request runs through a shadow list that predicts status, read data, count
// and cursor. A monitor behind a stalling receiver compares every result in order.
// ----------------------------------------------------------------------------
module tb_cursor_array_list_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = 1024;
	localparam int RANDOM_CNT = 536;

	typedef logic [cal_pkg::ACT_W-1:0]    act_bits_t;
	typedef logic [cal_pkg::POS_W-1:0]    pos_bits_t;
	typedef logic [cal_pkg::COUNT_W-1:0]  count_bits_t;
	typedef logic [cal_pkg::CURSOR_W-1:0] cursor_bits_t;

	typedef struct {
		logic [cal_pkg::ACT_W-1:0]   action;
		logic [cal_pkg::VALUE_W-1:0] value;
		logic [cal_pkg::POS_W-1:0]   position;
	} list_req_t;

	typedef struct {
		cal_pkg::status_t             status;
		logic [cal_pkg::DATA_W-1:0]   data;
		logic [cal_pkg::COUNT_W-1:0]  count;
		logic [cal_pkg::CURSOR_W-1:0] cursor;
	} list_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // value[31:0], position[41:32], zero fill
	logic [3:0]  s_tuser;   // action[3:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // data[31:0], count[42:32], cursor_at[52:43], zero fill
	logic [2:0]  m_tuser;   // status[2:0]

	list_req_t    pending_requests[$];
	list_result_t awaited_results[$];

	logic [cal_pkg::DATA_W-1:0] list_store [DEPTH];
	int                         list_len;
	int                         list_cursor;

	int burst_left;
	int gap_left;
	int ready_left;
	bit ready_level;
	int fail_count;

	cursor_array_list_core #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(cal_pkg::DATA_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	function automatic list_result_t apply_list_action(list_req_t req);
		list_result_t res;
		int i;
		res.status = cal_pkg::ST_OK;
		res.data   = '0;
		case (req.action) inside
		cal_pkg::ACT_INS_BEFORE, cal_pkg::ACT_INS_AFTER: begin
			if (list_len >= DEPTH) begin
				res.status = cal_pkg::ST_FULL;
			end else if (list_len == 0) begin
				list_store[0] = req.value;
				list_cursor   = 0;
				list_len      = 1;
			end else if (req.action == cal_pkg::ACT_INS_BEFORE) begin
				for (i = list_len; i > list_cursor; i--)
					list_store[i] = list_store[i-1];
				list_store[list_cursor] = req.value;
				list_cursor++;
				list_len++;
			end else begin
				for (i = list_len; i > list_cursor + 1; i--)
					list_store[i] = list_store[i-1];
				list_store[list_cursor+1] = req.value;
				list_len++;
			end
		end
		cal_pkg::ACT_DELETE: begin
			if (list_len == 0) begin
				res.status = cal_pkg::ST_EMPTY;
			end else if (list_cursor + 1 == list_len && list_cursor != 0) begin
				list_cursor = list_len - 2;
				list_len--;
			end else begin
				for (i = list_cursor; i < list_len - 1; i++)
					list_store[i] = list_store[i+1];
				list_len--;
			end
		end
		cal_pkg::ACT_PREV: begin
			if (list_len == 0)
				res.status = cal_pkg::ST_EMPTY;
			else if (list_cursor == 0)
				res.status = cal_pkg::ST_BOUND;
			else
				list_cursor--;
		end
		cal_pkg::ACT_NEXT: begin
			if (list_len == 0)
				res.status = cal_pkg::ST_EMPTY;
			else if (list_cursor + 1 >= list_len)
				res.status = cal_pkg::ST_BOUND;
			else
				list_cursor++;
		end
		cal_pkg::ACT_FIRST: begin
			if (list_len == 0)
				res.status = cal_pkg::ST_EMPTY;
			else
				list_cursor = 0;
		end
		cal_pkg::ACT_LAST: begin
			if (list_len == 0)
				res.status = cal_pkg::ST_EMPTY;
			else
				list_cursor = list_len - 1;
		end
		cal_pkg::ACT_READ_CUR: begin
			if (list_len == 0)
				res.status = cal_pkg::ST_EMPTY;
			else if (list_cursor >= list_len)
				res.status = cal_pkg::ST_BADIDX;
			else
				res.data = list_store[list_cursor];
		end
		cal_pkg::ACT_READ_IDX: begin
			if (req.position >= list_len)
				res.status = cal_pkg::ST_BADIDX;
			else
				res.data = list_store[req.position];
		end
		cal_pkg::ACT_WRITE_IDX: begin
			if (req.position >= list_len)
				res.status = cal_pkg::ST_BADIDX;
			else
				list_store[req.position] = req.value;
		end
		default: begin
		end
		endcase
		res.count  = count_bits_t'(list_len);
		res.cursor = cursor_bits_t'(list_cursor);
		return res;
	endfunction

	task automatic queue_request(logic [cal_pkg::ACT_W-1:0] action,
			logic [cal_pkg::VALUE_W-1:0] value, logic [cal_pkg::POS_W-1:0] position);
		list_req_t req;
		req.action   = action;
		req.value    = value;
		req.position = position;
		pending_requests.push_back(req);
	endtask

	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || awaited_results.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin : drive
			list_req_t req;
			if (s_tvalid && s_tready) begin
				req.action   = s_tuser;
				req.value    = s_tdata[31:0];
				req.position = s_tdata[41:32];
				awaited_results.push_back(apply_list_action(req));
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					req = pending_requests.pop_front();
					s_tdata  <= {6'b0, req.position, req.value};
					s_tuser  <= req.action;
					s_tvalid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			ready_left  = 0;
			ready_level = 1'b0;
			fail_count  = 0;
		end else begin : observe
			list_result_t want;
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected transfer: st=%0d data=%h count=%0d cur=%0d",
							m_tuser, m_tdata[31:0], m_tdata[42:32], m_tdata[52:43]);
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser !== want.status || m_tdata[31:0] !== want.data
							|| m_tdata[42:32] !== want.count
							|| m_tdata[52:43] !== want.cursor) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: exp st=%0d data=%h count=%0d cur=%0d",
								want.status, want.data, want.count, want.cursor);
							$display("          got st=%0d data=%h count=%0d cur=%0d",
								m_tuser, m_tdata[31:0], m_tdata[42:32], m_tdata[52:43]);
						end
					end
				end
			end
			if (ready_left == 0) begin
				ready_level = !ready_level;
				if (ready_level)
					ready_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
				else
					ready_left = $urandom_range(1, 12);
			end
			ready_left--;
			m_tready <= ready_level;
		end
	end

	initial begin : stimulus
		int len_guess;
		int sent;
		int chunk;
		int pick;
		int ins_w;
		int del_w;
		int k;
		logic [cal_pkg::ACT_W-1:0]   act;
		logic [cal_pkg::VALUE_W-1:0] val;
		logic [cal_pkg::POS_W-1:0]   pos;

		list_len    = 0;
		list_cursor = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// empty list: every action that needs an entry is refused
		queue_request(cal_pkg::ACT_DELETE, '0, '0);
		queue_request(cal_pkg::ACT_PREV, '1, '1);
		queue_request(cal_pkg::ACT_NEXT, '0, '0);
		queue_request(cal_pkg::ACT_FIRST, '0, '0);
		queue_request(cal_pkg::ACT_LAST, '0, '0);
		queue_request(cal_pkg::ACT_READ_CUR, '0, '0);
		queue_request(cal_pkg::ACT_READ_IDX, '0, '0);
		queue_request(cal_pkg::ACT_WRITE_IDX, 32'h1234_5678, '1);
		queue_request('1, '1, '1);
		// insert into empty list, then delete the only entry
		queue_request(cal_pkg::ACT_INS_AFTER, '1, '0);
		queue_request(cal_pkg::ACT_DELETE, '0, '0);
		queue_request(cal_pkg::ACT_INS_BEFORE, '0, '0);
		queue_request(cal_pkg::ACT_INS_BEFORE, 32'hA5A5_A5A5, '0);
		queue_request(cal_pkg::ACT_INS_AFTER, 32'h5A5A_5A5A, '0);
		queue_request(cal_pkg::ACT_PREV, '0, '0);
		queue_request(cal_pkg::ACT_PREV, '0, '0);
		queue_request(cal_pkg::ACT_NEXT, '0, '0);
		queue_request(cal_pkg::ACT_NEXT, '0, '0);
		queue_request(cal_pkg::ACT_NEXT, '0, '0);
		queue_request(cal_pkg::ACT_READ_CUR, '0, '0);
		queue_request(cal_pkg::ACT_READ_IDX, '0, 10'd2);
		queue_request(cal_pkg::ACT_WRITE_IDX, 32'hDEAD_BEEF, 10'd1);
		queue_request(cal_pkg::ACT_READ_IDX, '0, 10'd1);
		// cursor on the last entry: delete steps it back
		queue_request(cal_pkg::ACT_LAST, '0, '0);
		queue_request(cal_pkg::ACT_DELETE, '0, '0);
		queue_request(act_bits_t'(cal_pkg::ACT_WRITE_IDX + 1), '0, '0);
		wait_for_drain();

		len_guess = list_len;
		sent      = 0;
		while (sent < RANDOM_CNT) begin
			chunk = $urandom_range(24, 64);
			for (k = 0; k < chunk; k++) begin
				if (len_guess < 4) begin
					ins_w = 45;
					del_w = 10;
				end else if (len_guess > 48) begin
					ins_w = 10;
					del_w = 35;
				end else begin
					ins_w = 24;
					del_w = 20;
				end
				pick = $urandom_range(0, 99);
				if (pick < ins_w)
					act = $urandom_range(0, 1) ? cal_pkg::ACT_INS_AFTER
						: cal_pkg::ACT_INS_BEFORE;
				else if (pick < ins_w + del_w)
					act = cal_pkg::ACT_DELETE;
				else if (pick < 96)
					act = act_bits_t'(cal_pkg::ACT_PREV
						+ $urandom_range(0, cal_pkg::ACT_WRITE_IDX - cal_pkg::ACT_PREV));
				else
					act = act_bits_t'(cal_pkg::ACT_WRITE_IDX
						+ $urandom_range(1, (1 << cal_pkg::ACT_W) - 1 - cal_pkg::ACT_WRITE_IDX));
				if ((act == cal_pkg::ACT_INS_BEFORE || act == cal_pkg::ACT_INS_AFTER)
						&& len_guess < DEPTH)
					len_guess++;
				else if (act == cal_pkg::ACT_DELETE && len_guess > 0)
					len_guess--;
				case ($urandom_range(0, 9))
				0: val = '0;
				1: val = '1;
				default: val = $urandom;
				endcase
				if ($urandom_range(0, 6) == 0)
					pos = pos_bits_t'($urandom_range(0, (1 << cal_pkg::POS_W) - 1));
				else
					pos = pos_bits_t'($urandom_range(0, len_guess + 2));
				queue_request(act, val, pos);
			end
			sent += chunk;
			if ($urandom_range(0, 3) == 0)
				wait_for_drain();
			else
				while (pending_requests.size() > 8)
					@(negedge clk);
		end
		wait_for_drain();

		// boundary cases on the list left by the random mix
		queue_request(cal_pkg::ACT_LAST, '0, '0);
		queue_request(cal_pkg::ACT_INS_BEFORE, '1, '0);
		queue_request(cal_pkg::ACT_INS_AFTER, '0, '1);
		queue_request(cal_pkg::ACT_LAST, '0, '0);
		queue_request(cal_pkg::ACT_NEXT, '0, '0);
		queue_request(cal_pkg::ACT_READ_CUR, '0, '0);
		queue_request(cal_pkg::ACT_WRITE_IDX, '1, '1);
		queue_request(cal_pkg::ACT_READ_IDX, '0, '1);
		queue_request(cal_pkg::ACT_FIRST, '0, '0);
		queue_request(cal_pkg::ACT_PREV, '0, '0);
		queue_request(cal_pkg::ACT_DELETE, '0, '0);
		queue_request(cal_pkg::ACT_LAST, '0, '0);
		queue_request(cal_pkg::ACT_DELETE, '0, '0);
		queue_request(cal_pkg::ACT_READ_IDX, '0, '0);
		queue_request(cal_pkg::ACT_READ_CUR, '0, '0);
		wait_for_drain();

		repeat (DEPTH + 10) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/cal_pkg.sv
rtl/cal_ram.sv
rtl/cal_seq.sv
rtl/cursor_array_list_core.sv
rtl/cal_chk.sv
bench/tb_cursor_array_list_core.sv
